// ===== src/hmg_pkg.sv =====
package hmg_pkg;

    localparam int HEIGHT_W = 24;
    localparam int CORNER_W = 25;
    localparam int COORD_W  = 12;
    localparam int CFG_W    = 11;

    localparam logic [1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [1:0] CFG_GRID_ROWS = 2'd1;

    localparam logic [CFG_W-1:0] GRID_RESET = 11'd64;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [15:0]        pos_x;
        logic [23:0]        height;
        logic [15:0]        pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               height_fault;
        logic               last;
    } t_vertex;

    // One cell handed from the front to the back. Corners carry the fault bit on top.
    typedef struct packed {
        logic [CORNER_W-1:0] ll;
        logic [CORNER_W-1:0] tl;
        logic [CORNER_W-1:0] tr;
        logic [CORNER_W-1:0] lr;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [CFG_W-1:0]    cols;
        logic [CFG_W-1:0]    rows;
    } t_cell;

    // Corner index for each of the six emitted vertices: ll, tl, tr, ll, tr, lr.
    function automatic logic [1:0] corner_of(input logic [2:0] k);
        logic [1:0] c;
        case (k)
            3'd0: c = 2'd0;
            3'd1: c = 2'd1;
            3'd2: c = 2'd2;
            3'd3: c = 2'd0;
            3'd4: c = 2'd2;
            3'd5: c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/hmg_div.sv =====
module hmg_div #(
    parameter int N = 32,
    parameter int D = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quo
);
    localparam int CW = $clog2(N);

    logic [N-1:0]  r_quo;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;

    logic [D:0] trial;
    logic       ge;
    logic [D:0] diff;

    always_comb begin
        trial = {r_rem, r_quo[N-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(N - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[N-2:0], ge};
            r_rem <= ge ? diff[D-1:0] : trial[D-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== src/hmg_queue.sv =====
module hmg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hmg_pkg::t_cell i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output hmg_pkg::t_cell o_item
);
    hmg_pkg::t_cell r_q0;
    hmg_pkg::t_cell r_q1;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_q0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && pop) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= i_item;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= i_item;
            end
        end else if (pop) begin
            r_q0 <= r_q1;
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_item;
            end else begin
                r_q1 <= i_item;
            end
        end
    end
endmodule

// ===== src/hmg_front.sv =====
module hmg_front #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hmg_pkg::t_pixel i_pixel,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [10:0]     i_cfg_data,
    output logic            o_cell_valid,
    input  logic            i_cell_ready,
    output hmg_pkg::t_cell  o_cell
);
    localparam int AW = $clog2(MAX_COLUMNS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD0  = 3'd1;
    localparam logic [2:0] ST_RD1  = 3'd2;
    localparam logic [2:0] ST_CALC = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]  r_st;
    logic [10:0] r_cols;
    logic [10:0] r_rows;
    logic [AW-1:0] r_x;
    logic [9:0]  r_y;
    logic [AW-1:0] r_cx;
    logic [9:0]  r_cy;
    logic [24:0] r_left;
    logic [24:0] r_ll;
    logic [24:0] r_rd;
    logic        r_bzero;
    hmg_pkg::t_cell r_cell;

    logic [24:0] mem [MAX_COLUMNS];

    logic [10:0] cols;
    logic [10:0] rows;
    logic [AW-1:0] acc_x;
    logic [9:0]  acc_y;
    logic        div_done;
    logic [31:0] div_quo;
    logic        accept;
    logic [24:0] cur;
    logic        last_col;
    logic        last_row;
    logic        has_cell;
    logic        we;
    logic [AW-1:0] wa;
    logic [24:0] wd;
    logic        re;
    logic [AW-1:0] ra;

    always_comb begin
        cols = r_cols;
        if (r_cols < 11'd2) begin
            cols = 11'd2;
        end else if (32'(r_cols) > MAX_COLUMNS) begin
            cols = 11'(MAX_COLUMNS);
        end
        rows = r_rows;
        if (r_rows < 11'd2) begin
            rows = 11'd2;
        end else if (r_rows > 11'd1024) begin
            rows = 11'd1024;
        end
        acc_x = (32'(r_x) >= 32'(cols)) ? AW'(cols - 11'd1) : r_x;
        acc_y = (32'(r_y) >= 32'(rows)) ? 10'(rows - 11'd1) : r_y;
    end

    assign accept   = i_valid && o_ready;
    assign o_ready  = r_st == ST_IDLE;
    assign cur      = r_bzero ? 25'h1FFFFFF : {1'b0, div_quo[23:0]};
    assign last_col = 32'(r_cx) + 32'd1 >= 32'(cols);
    assign last_row = 32'(r_cy) + 32'd1 >= 32'(rows);
    assign has_cell = (r_cx != '0) && (r_cy != '0);

    hmg_div #(.N(32), .D(16)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend ({16'(i_pixel.red) * 16'(i_pixel.green), 16'h0000}),
        .i_divisor  (16'(i_pixel.blue) * 16'd255),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Line store: read ll then lr, overwrite the left slot after it has been read.
    always_comb begin
        re = (r_st == ST_RD0) || (r_st == ST_RD1);
        ra = (r_st == ST_RD0) ? r_cx - 1'b1 : r_cx;
        we = 1'b0;
        wa = r_cx;
        wd = cur;
        if (r_st == ST_RD1 && r_cx != '0) begin
            we = 1'b1;
            wa = r_cx - 1'b1;
            wd = r_left;
        end else if (r_st == ST_CALC && div_done && last_col) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rd <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_cols <= hmg_pkg::GRID_RESET;
            r_rows <= hmg_pkg::GRID_RESET;
            r_x    <= '0;
            r_y    <= '0;
            r_left <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == hmg_pkg::CFG_GRID_COLS) begin
                    r_cols <= i_cfg_data;
                    r_x    <= '0;
                    r_y    <= '0;
                end else if (i_cfg_index == hmg_pkg::CFG_GRID_ROWS) begin
                    r_rows <= i_cfg_data;
                    r_x    <= '0;
                    r_y    <= '0;
                end
            end
            case (r_st)
                ST_IDLE: begin
                    if (accept) begin
                        r_st <= ST_RD0;
                    end
                end
                ST_RD0: r_st <= ST_RD1;
                ST_RD1: r_st <= ST_CALC;
                ST_CALC: begin
                    if (div_done) begin
                        r_left <= cur;
                        if (last_col) begin
                            r_x <= '0;
                            r_y <= last_row ? 10'd0 : r_cy + 10'd1;
                        end else begin
                            r_x <= r_cx + 1'b1;
                            r_y <= r_cy;
                        end
                        r_st <= has_cell ? ST_PUSH : ST_IDLE;
                    end
                end
                ST_PUSH: begin
                    if (i_cell_ready) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx    <= acc_x;
            r_cy    <= acc_y;
            r_bzero <= i_pixel.blue == 8'd0;
        end
        if (r_st == ST_RD1) begin
            r_ll <= r_rd;
        end
        if (r_st == ST_CALC && div_done) begin
            r_cell.ll   <= r_ll;
            r_cell.lr   <= r_rd;
            r_cell.tl   <= r_left;
            r_cell.tr   <= cur;
            r_cell.x    <= hmg_pkg::COORD_W'(r_cx);
            r_cell.y    <= hmg_pkg::COORD_W'(r_cy);
            r_cell.cols <= cols;
            r_cell.rows <= rows;
        end
    end

    assign o_cell_valid = r_st == ST_PUSH;
    assign o_cell       = r_cell;
endmodule

// ===== src/hmg_back.sv =====
module hmg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cell_valid,
    output logic             o_cell_ready,
    input  hmg_pkg::t_cell   i_cell,
    output logic             o_valid,
    input  logic             i_ready,
    output hmg_pkg::t_vertex o_vertex
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_DIVS = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]  r_st;
    logic [2:0]  r_k;
    logic        r_busy;
    hmg_pkg::t_cell r_cell;
    logic [35:0] r_m0;
    logic [35:0] r_m1;
    logic [35:0] r_m2;
    logic        r_neg0;
    logic        r_neg2;
    logic [59:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [15:0] r_n0;
    logic [15:0] r_n1;
    logic [15:0] r_n2;
    logic [15:0] r_px0;
    logic [15:0] r_px1;
    logic [15:0] r_pz0;
    logic [15:0] r_pz1;
    logic        r_ovalid;
    hmg_pkg::t_vertex r_out;

    logic signed [24:0] dx;
    logic signed [24:0] dz;
    logic signed [37:0] vx;
    logic signed [37:0] vz;
    logic [35:0] mx;
    logic [29:0] sq_in;
    logic [63:0] trial;
    logic        div_start;
    logic [45:0] dvd;
    logic [31:0] dvs;
    logic        div_done;
    logic [45:0] div_quo;
    logic        out_free;
    logic [1:0]  corner;
    logic [24:0] corner_h;
    logic [15:0] q_signed;

    always_comb begin
        dx = $signed({1'b0, i_cell.tl[23:0]}) - $signed({1'b0, i_cell.tr[23:0]});
        dz = $signed({1'b0, i_cell.ll[23:0]}) - $signed({1'b0, i_cell.tl[23:0]});
        vx = 38'($signed({1'b0, i_cell.cols})) * 38'(dx);
        vz = 38'($signed({1'b0, i_cell.rows})) * 38'(dz);
        mx = r_m0;
        if (r_m1 > mx) begin
            mx = r_m1;
        end
        if (r_m2 > mx) begin
            mx = r_m2;
        end
        case (r_k)
            3'd0:    sq_in = r_m0[29:0];
            3'd1:    sq_in = r_m1[29:0];
            default: sq_in = r_m2[29:0];
        endcase
        trial = r_res + r_bit;
    end

    // One shared divider: three normal components, then four grid positions.
    always_comb begin
        dvd = 46'({r_cell.x - 1'b1, 16'h0000});
        dvs = 32'(r_cell.cols);
        case (r_k)
            3'd0: begin
                dvd = 46'({r_m0[29:0], 15'h0000}) + 46'(r_res);
                dvs = {r_res[30:0], 1'b0};
            end
            3'd1: begin
                dvd = 46'({r_m1[29:0], 15'h0000}) + 46'(r_res);
                dvs = {r_res[30:0], 1'b0};
            end
            3'd2: begin
                dvd = 46'({r_m2[29:0], 15'h0000}) + 46'(r_res);
                dvs = {r_res[30:0], 1'b0};
            end
            3'd3: dvd = 46'({r_cell.x - 1'b1, 16'h0000});
            3'd4: dvd = 46'({r_cell.x, 16'h0000});
            3'd5: begin
                dvd = 46'({r_cell.y - 1'b1, 16'h0000});
                dvs = 32'(r_cell.rows);
            end
            3'd6: begin
                dvd = 46'({r_cell.y, 16'h0000});
                dvs = 32'(r_cell.rows);
            end
            default: dvd = '0;
        endcase
    end

    assign div_start = (r_st == ST_DIVS) && !r_busy;

    hmg_div #(.N(46), .D(32)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    assign q_signed = ((r_k == 3'd0 && r_neg0) || (r_k == 3'd2 && r_neg2))
                    ? 16'h0000 - div_quo[15:0] : div_quo[15:0];

    assign out_free     = !r_ovalid || i_ready;
    assign o_cell_ready = r_st == ST_IDLE;
    assign corner       = hmg_pkg::corner_of(r_k);

    always_comb begin
        case (corner)
            2'd0:    corner_h = r_cell.ll;
            2'd1:    corner_h = r_cell.tl;
            2'd2:    corner_h = r_cell.tr;
            default: corner_h = r_cell.lr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_k      <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_cell_valid) begin
                        r_st <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (mx[35:29] == 7'd1) begin
                        r_st <= ST_SQ;
                        r_k  <= '0;
                    end
                end
                ST_SQ: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd3) begin
                        r_st <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_bit == '0) begin
                        r_st <= ST_DIVS;
                        r_k  <= '0;
                    end
                end
                ST_DIVS: begin
                    if (!r_busy) begin
                        r_busy <= 1'b1;
                    end else if (div_done) begin
                        r_busy <= 1'b0;
                        r_k    <= r_k + 3'd1;
                        if (r_k == 3'd6) begin
                            r_st <= ST_EMIT;
                            r_k  <= '0;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_k      <= r_k + 3'd1;
                        if (r_k == 3'd5) begin
                            r_st <= ST_IDLE;
                            r_k  <= '0;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                if (i_cell_valid) begin
                    r_cell <= i_cell;
                    r_m0   <= vx[37] ? 36'(-vx) : vx[35:0];
                    r_m1   <= 36'd65536;
                    r_m2   <= vz[37] ? 36'(-vz) : vz[35:0];
                    r_neg0 <= vx[37];
                    r_neg2 <= vz[37];
                end
            end
            ST_NORM: begin
                if (mx[35:30] != '0) begin
                    r_m0 <= r_m0 >> 1;
                    r_m1 <= r_m1 >> 1;
                    r_m2 <= r_m2 >> 1;
                end else if (mx[29] == 1'b0) begin
                    r_m0 <= r_m0 << 1;
                    r_m1 <= r_m1 << 1;
                    r_m2 <= r_m2 << 1;
                end
            end
            ST_SQ: begin
                r_prod <= sq_in * sq_in;
                if (r_k == 3'd0) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= r_acc + 64'(r_prod);
                end
                if (r_k == 3'd3) begin
                    r_v   <= r_acc + 64'(r_prod);
                    r_res <= '0;
                    r_bit <= 64'h4000_0000_0000_0000;
                end
            end
            ST_SQRT: begin
                if (r_bit != '0) begin
                    if (r_v >= trial) begin
                        r_v   <= r_v - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            ST_DIVS: begin
                if (r_busy && div_done) begin
                    case (r_k)
                        3'd0:    r_n0  <= q_signed;
                        3'd1:    r_n1  <= q_signed;
                        3'd2:    r_n2  <= q_signed;
                        3'd3:    r_px0 <= div_quo[15:0];
                        3'd4:    r_px1 <= div_quo[15:0];
                        3'd5:    r_pz0 <= div_quo[15:0];
                        default: r_pz1 <= div_quo[15:0];
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out.pos_x    <= (corner == 2'd0 || corner == 2'd1) ? r_px0 : r_px1;
                    r_out.pos_z    <= (corner == 2'd0 || corner == 2'd3) ? r_pz0 : r_pz1;
                    r_out.height   <= corner_h[23:0];
                    r_out.normal_x <= r_n0;
                    r_out.normal_y <= r_n1;
                    r_out.normal_z <= r_n2;
                    r_out.height_fault <= r_cell.ll[24] | r_cell.tl[24]
                                        | r_cell.tr[24] | r_cell.lr[24];
                    r_out.last     <= r_k == 3'd5;
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_vertex = r_out;
endmodule

// ===== src/heightmap_mesh_generator_core.sv =====
// Front: takes one pixel at a time and runs it through the 32-step height divider.
// Back: per cell, up to 13 normalize shifts, a bit-by-bit square root and seven divisions
// on one shared divider, then six vertices leave one per cycle while the output is not stalled.
// Reset is synchronous, active low: counters go to zero, grid sizes to 64.
// The line store is not cleared and holds nothing valid until a row has been written.
module heightmap_mesh_generator_core #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hmg_pkg::t_pixel  i_pixel,
    output logic             o_valid,
    input  logic             i_ready,
    output hmg_pkg::t_vertex o_vertex,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [10:0]      i_cfg_data
);
    logic           front_valid;
    logic           front_ready;
    hmg_pkg::t_cell front_cell;
    logic           back_valid;
    logic           back_ready;
    hmg_pkg::t_cell back_cell;

    assign o_cfg_ready = 1'b1;

    hmg_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cell_valid (front_valid),
        .i_cell_ready (front_ready),
        .o_cell       (front_cell)
    );

    hmg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_cell),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_item  (back_cell)
    );

    hmg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (back_valid),
        .o_cell_ready (back_ready),
        .i_cell       (back_cell),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_vertex     (o_vertex)
    );
endmodule

// ===== src/hmg_checker.sv =====
module hmg_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input hmg_pkg::t_vertex o_vertex
);
    // A stalled item stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_vertex))
        else $error("output item changed while stalled");

    // Six vertices per cell, so two accepted last flags never come back to back.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_vertex.last |=> !(o_valid && o_vertex.last))
        else $error("cell ended twice in a row");

    // The up component of the face normal is never negative; steep cells round it to zero.
    a_ny: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_vertex.normal_y >= 16'sd0 && o_vertex.normal_y <= 16'sd16384)
        else $error("normal_y out of range");

    a_nx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_vertex.normal_x >= -16'sd16384 && o_vertex.normal_x <= 16'sd16384)
        else $error("normal_x out of range");
endmodule

bind heightmap_mesh_generator_core hmg_checker u_hmg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_vertex (o_vertex)
);
